[hw/rtl/bgre_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgre_pkg: shared types and constants
// Beat layouts, operation codes, register indexes and store geometry.
// ----------------------------------------------------------------------------
package bgre_pkg;

  // Glyph store geometry (power of two, word addresses wrap)
  localparam int GLYPH_WORDS  = 4096;
  localparam int GLYPH_AW     = $clog2(GLYPH_WORDS);
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int MAX_RUNS     = 32;
  localparam int WORD_W       = 16;

  localparam logic [7:0] DOT_CODE = 8'd46;

  // Operation codes
  localparam logic [1:0] OP_DRAW   = 2'd0;
  localparam logic [1:0] OP_CURSOR = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_FIRST_CODE   = 3'd0;
  localparam logic [2:0] CFG_LAST_CODE    = 3'd1;
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_MSB_POSITION = 3'd4;
  localparam logic [2:0] CFG_DOT_MASK     = 3'd5;
  localparam logic [2:0] CFG_DOT_ADVANCE  = 3'd6;
  localparam logic [2:0] CFG_LAYOUT_MODE  = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic        color;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;
    logic [11:0] glyph_address;
    logic [15:0] glyph_word;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] pixels;
    logic [4:0]  pixel_count;
    logic        run_vertical;
    logic        last;
  } out_item_t;

endpackage

[hw/rtl/bgre_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgre_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held when idle.
// ----------------------------------------------------------------------------
module bgre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bitmap_glyph_row_expander.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_row_expander: bitmap font glyph renderer
// Glyph store, text cursor and run expansion of glyph words into pixel beats.
// ----------------------------------------------------------------------------
// A draw beat looks up the glyph of char_code and sends one output beat per
// glyph row (or per column when layout_mode bit0 is set), each carrying the
// pixels of that word from msb_position down, packed from bit0 and inverted
// when color is 0. At most 32 runs are sent; the cursor advances by the full
// glyph size (or dot_advance for '.'). A draw with code 0, a code outside
// first_code..last_code, or a glyph that would run past the frame edge gives
// a single beat with accepted low and last high, and leaves the cursor alone.
// Set cursor and glyph write beats send nothing; a draw of a word never
// written before it reads back undefined pixels.
// Rate: the glyph memory read port delivers one word per cycle while the
// output is not stalled, so a draw with R runs (R = min(words per glyph,
// 32)) streams R beats back to back while out_ready stays high. The next
// input beat is taken once the last word or rejected marker has left the
// memory stage; an empty glyph sends no beat. Configuration writes are taken
// at any cycle but must only change while no draw is in flight.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_expander (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgre_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bgre_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  import bgre_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Configuration registers
  logic [7:0]  first_code;
  logic [7:0]  last_code;
  logic [4:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [3:0]  msb_position;
  logic [15:0] dot_mask;
  logic [4:0]  dot_advance;
  logic [1:0]  layout_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code   <= 8'd32;
      last_code    <= 8'd126;
      glyph_width  <= 5'd8;
      glyph_height <= 6'd16;
      msb_position <= 4'd7;
      dot_mask     <= 16'hFFFF & 16'd255;
      dot_advance  <= 5'd8;
      layout_mode  <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_CODE:   first_code   <= cfg_data[7:0];
        CFG_LAST_CODE:    last_code    <= cfg_data[7:0];
        CFG_GLYPH_WIDTH:  glyph_width  <= cfg_data[4:0];
        CFG_GLYPH_HEIGHT: glyph_height <= cfg_data[5:0];
        CFG_MSB_POSITION: msb_position <= cfg_data[3:0];
        CFG_DOT_MASK:     dot_mask     <= cfg_data;
        CFG_DOT_ADVANCE:  dot_advance  <= cfg_data[4:0];
        CFG_LAYOUT_MODE:  layout_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic col_major, vert_text;
  assign col_major = layout_mode[0];
  assign vert_text = layout_mode[1];

  // Control state
  state_t      state, state_next;
  logic [7:0]  cursor_col, cursor_row;
  logic [4:0]  run_idx;
  logic        s1_valid;   // glyph word in flight from memory
  logic        s1_rej;
  logic        s1_last;
  logic [4:0]  s1_idx;

  // Per-draw context, loaded when a draw is taken
  logic [7:0]        x0, y0;
  logic [13:0]       base;
  logic [4:0]        runs_m1;
  logic              color_r;
  logic [WORD_W-1:0] kept;
  logic [3:0]        dest [WORD_W];
  logic [4:0]        kept_n;

  // Input decode
  logic       in_fire, is_draw, is_cursor, is_write;
  logic       reject, is_dot;
  logic [5:0] words;
  logic [5:0] runs;
  logic [7:0] code_off;
  logic [7:0] advance;

  assign in_ready = (state == ST_IDLE) && !s1_valid;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    is_draw   = 1'b0;
    is_cursor = 1'b0;
    is_write  = 1'b0;
    case (in_data.operation)
      OP_DRAW:   is_draw   = 1'b1;
      OP_CURSOR: is_cursor = 1'b1;
      OP_WRITE:  is_write  = 1'b1;
      default: ;
    endcase
  end

  assign is_dot = (in_data.char_code == DOT_CODE);
  assign reject = (in_data.char_code == 8'd0)
               || (in_data.char_code < first_code)
               || (in_data.char_code > last_code)
               || (({1'b0, cursor_col} + 9'(glyph_width)) > 9'(FRAME_WIDTH))
               || (({1'b0, cursor_row} + 9'(glyph_height)) > 9'(FRAME_HEIGHT));
  assign words    = col_major ? 6'(glyph_width) : glyph_height;
  assign runs     = (words > 6'(MAX_RUNS)) ? 6'(MAX_RUNS) : words;
  assign code_off = in_data.char_code - first_code;
  assign advance  = is_dot ? 8'(dot_advance)
                  : (vert_text ? 8'(glyph_height) : 8'(glyph_width));

  // Bit selection: which word bits are kept and where each one lands
  logic [WORD_W-1:0] kept_c;
  logic [3:0]        dest_c [WORD_W];

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      kept_c[k] = (4'(k) <= msb_position) && (!is_dot || dot_mask[k]);
    end
    for (int k = 0; k < WORD_W; k++) begin
      dest_c[k] = 4'($countones(kept_c >> (k + 1)));
    end
  end

  // Glyph memory
  logic                ram_we, ram_re;
  logic [GLYPH_AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  assign ram_we    = in_fire && is_write
                  && (32'(in_data.glyph_address) < GLYPH_WORDS);
  assign ram_waddr = GLYPH_AW'(in_data.glyph_address);
  assign ram_raddr = GLYPH_AW'({1'b0, base} + 15'(run_idx));

  bgre_ram #(
    .WIDTH (WORD_W),
    .DEPTH (GLYPH_WORDS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.glyph_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read issue and the memory stage handoff
  logic s1_adv, issue, issue_last;

  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign issue      = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign issue_last = (run_idx == runs_m1);
  assign ram_re     = issue;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && is_draw && !reject && (runs != 6'd0)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
      run_idx    <= 5'd0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (in_fire && is_cursor) begin
        cursor_col <= in_data.cursor_x;
        cursor_row <= in_data.cursor_y;
      end else if (in_fire && is_draw && !reject) begin
        if (vert_text) begin
          cursor_row <= cursor_row + advance;
        end else begin
          cursor_col <= cursor_col + advance;
        end
      end

      if (in_fire) begin
        run_idx <= 5'd0;
      end else if (issue) begin
        run_idx <= run_idx + 5'd1;
      end

      // A rejected draw goes straight into the memory stage as a marker beat
      if (in_fire && is_draw && reject) begin
        s1_valid <= 1'b1;
      end else if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [WORD_W-1:0] px_c;

  always_comb begin
    px_c = '0;
    for (int j = 0; j < WORD_W; j++) begin
      for (int k = 0; k < WORD_W; k++) begin
        if (kept[k] && (dest[k] == 4'(j))) begin
          px_c[j] = ram_rdata[k] ~^ color_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_draw) begin
      x0      <= cursor_col;
      y0      <= cursor_row;
      base    <= 14'(code_off * words);
      runs_m1 <= 5'(runs - 6'd1);
      color_r <= in_data.color;
      kept    <= kept_c;
      dest    <= dest_c;
      kept_n  <= 5'($countones(kept_c));
      s1_rej  <= reject;
      s1_last <= 1'b1;
    end else if (issue) begin
      s1_rej  <= 1'b0;
      s1_idx  <= run_idx;
      s1_last <= issue_last;
    end

    if (s1_adv) begin
      if (s1_rej) begin
        out_data.accepted     <= 1'b0;
        out_data.pos_x        <= 8'd0;
        out_data.pos_y        <= 8'd0;
        out_data.pixels       <= '0;
        out_data.pixel_count  <= 5'd0;
        out_data.run_vertical <= 1'b0;
        out_data.last         <= 1'b1;
      end else begin
        out_data.accepted     <= 1'b1;
        out_data.pos_x        <= col_major ? x0 + 8'(s1_idx) : x0;
        out_data.pos_y        <= col_major ? y0 : y0 + 8'(s1_idx);
        out_data.pixels       <= px_c;
        out_data.pixel_count  <= kept_n;
        out_data.run_vertical <= col_major;
        out_data.last         <= s1_last;
      end
    end
  end

endmodule

[hw/rtl/bgre_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgre_checker: port-level checks for the glyph row expander
// Watches both beat channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bgre_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input bgre_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bgre_pkg::out_item_t out_data
);

  import bgre_pkg::*;

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // rejected draw is a single empty closing beat
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |->
      out_data.last && (out_data.pixel_count == 5'd0) && (out_data.pixels == 16'd0))
    else $error("rejected beat malformed");

  // no more pixels than a glyph word holds
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pixel_count <= 5'd16)
    else $error("pixel count out of range");

  // pixels beyond the count stay clear
  a_pixels_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pixel_count == 5'd16)
               || ((out_data.pixels >> out_data.pixel_count) == 16'd0))
    else $error("pixels set beyond pixel count");

endmodule

bind bitmap_glyph_row_expander bgre_checker u_bgre_checker (.*);
